// ===== src/ibt_pkg.sv =====
// Shared constants and types for the interval booking table.
package ibt_pkg;

    // Table size and time resolution
    localparam int MAX_ENTRIES = 64;
    localparam int TIME_WIDTH  = 32;

    // Derived widths: entry index and fill count (count must hold MAX_ENTRIES)
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // Stream payload widths
    localparam int FIELD_W   = 32;
    localparam int S_TDATA_W = 2 * FIELD_W;
    localparam int STATUS_W  = 2;
    localparam int M_TDATA_W = 8;

    // One stored entry: {end, start}
    localparam int ENTRY_W = 2 * TIME_WIDTH;

    typedef logic [TIME_WIDTH-1:0] t_time;

    // Result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_BOOKED   = 2'd0,
        ST_CONFLICT = 2'd1,
        ST_FULL     = 2'd2,
        ST_INVALID  = 2'd3
    } t_status;

endpackage

// ===== src/ibt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module ibt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/interval_booking_table.sv =====
// Interval booking table: scans stored half-open intervals and books a new one if free.
//
// Each item asks to book [start_time, end_time). The block walks the stored
// intervals one per cycle through a single RAM read port with registered
// read data and stops at the first overlap. An empty or reversed interval is
// answered without a scan; otherwise the scan covers the intervals already
// stored (at most MAX_ENTRIES = 64) and ends early when an overlap is found.
// One item is worked on at a time; a finished result sits in an output
// register so the next item can be taken while it waits. The table is empty
// after reset and needs no clearing pass: only entries below the fill count
// are ever checked.
module interval_booking_table
    import ibt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave side, tdata: start_time[31:0], end_time[63:32]
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // master side, tdata: status[1:0], zero fill[7:2]
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state           r_state;
    t_time            r_start;
    t_time            r_end;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_idx;
    logic             r_pend;
    t_status          r_status;
    logic             r_out_valid;
    t_status          r_out_status;

    t_time            n_start;
    t_time            n_end;
    logic [ENTRY_W-1:0] rd_data;
    t_time            rd_start;
    t_time            rd_end;
    logic             hit;
    logic             more;
    logic             wr_en;
    logic             out_load;

    // Unpack the request and fit it to the time width
    assign n_start = TIME_WIDTH'(i_s_tdata[FIELD_W-1:0]);
    assign n_end   = TIME_WIDTH'(i_s_tdata[S_TDATA_W-1:FIELD_W]);

    assign rd_start = rd_data[TIME_WIDTH-1:0];
    assign rd_end   = rd_data[ENTRY_W-1:TIME_WIDTH];

    // Overlap of the entry read last cycle with the request
    assign hit  = r_pend && (r_start < rd_end) && (rd_start < r_end);
    assign more = (r_idx < r_count);

    // Append once the whole table was scanned without overlap and room is left
    assign wr_en = (r_state == S_SCAN) && !more && !hit
                   && (r_count != CNT_W'(MAX_ENTRIES));

    // Move a finished result into the output register once it is free
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_m_tready);

    ibt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data ({r_end, r_start}),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    // Sequencer, fill count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Load a new result or drop the one just taken
            if (out_load) begin
                r_out_valid  <= 1'b1;
                r_out_status <= r_status;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_start <= n_start;
                        r_end   <= n_end;
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        if (!(n_start < n_end)) begin
                            r_status <= ST_INVALID;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // Issue the next read and check the one returned
                    r_pend <= more;
                    if (more) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (hit) begin
                        r_status <= ST_CONFLICT;
                        r_state  <= S_DONE;
                    end else if (!more) begin
                        if (wr_en) begin
                            r_count  <= r_count + 1'b1;
                            r_status <= ST_BOOKED;
                        end else begin
                            r_status <= ST_FULL;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hand the result over once the output register is free
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(M_TDATA_W - STATUS_W)'(0), r_out_status};

endmodule

// ===== src/ibt_checker.sv =====
// Port-level checks for the interval booking table, bound to the top level.
module ibt_checker
    import ibt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] o_m_tdata
);

    logic [1:0] r_pending;
    logic       s_acc;
    logic       m_acc;

    assign s_acc = i_s_tvalid && o_s_tready;
    assign m_acc = o_m_tvalid && i_m_tready;

    // Track items taken but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (s_acc && !m_acc) begin
            r_pending <= r_pending + 1'b1;
        end else if (m_acc && !s_acc) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    // At most one item in work plus one result waiting
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3)
        else $error("more than two items outstanding");

    // No result without an item behind it
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> r_pending != 2'd0)
        else $error("result shown with no item outstanding");

    // One item at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_tready)
        else $error("input taken while an item is in work");

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

bind interval_booking_table ibt_checker u_ibt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
